// ===== hdl/integer_to_ascii_formatter_core_assert.svh =====
// Assertion macros for the formatter modules, used by the emitter.
// I2A_ASSERT checks on clk with reset masking; I2A_ASSERT_ALWAYS checks on clk in and out of reset.
`ifndef INTEGER_TO_ASCII_FORMATTER_CORE_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define I2A_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("formatter assertion failed");

`define I2A_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("formatter assertion failed");

`else

`define I2A_ASSERT(lbl, prop)

`define I2A_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ===== hdl/i2a_pkg.sv =====
package i2a_pkg;

    typedef enum logic [1:0] {
        FUNC_BIN = 2'd0,
        FUNC_HEX = 2'd1,
        FUNC_DEC = 2'd2,
        FUNC_BAD = 2'd3
    } func_t;

    // per-item formatting control handed from converter to emitter
    typedef struct packed {
        logic  neg;
        func_t func;
        logic  prefix;
    } desc_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [3:0] NIB_NINE = 4'd9;
    localparam logic [3:0] NIB_TEN  = 4'd10;

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
        logic [7:0] base;
        base = upper ? CH_UA : CH_LA;
        if (nib <= NIB_NINE)
            return CH_ZERO + {4'd0, nib};
        return base + {4'd0, nib - NIB_TEN};
    endfunction

endpackage

// ===== hdl/i2a_bcd_cell.sv =====
// One BCD digit of the shift-add-3 chain.
module i2a_bcd_cell (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       clear,
    input  logic       shift_en,
    input  logic       cin,
    output logic       cout,
    output logic [3:0] digit
);

    logic [3:0] digit_reg;
    logic [3:0] adj;

    assign adj   = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
    assign cout  = adj[3];
    assign digit = digit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= 4'd0;
        end
        else if (clear)
        begin
            digit_reg <= 4'd0;
        end
        else if (shift_en)
        begin
            digit_reg <= {adj[2:0], cin};
        end
    end

endmodule

// ===== hdl/i2a_convert.sv =====
// Takes one beat, forms sign and magnitude, then shifts the magnitude MSB first
// through the BCD chain while noting the top set bit.
module i2a_convert #(
    parameter int W    = 32,
    parameter int NDIG = 10,
    parameter int PW   = 5
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [W-1:0]            value,
    input  logic [1:0]              func,
    input  logic                    with_prefix,
    output logic                    cv_valid,
    input  logic                    cv_take,
    output i2a_pkg::desc_t          cv_desc,
    output logic [W-1:0]            cv_mag,
    output logic [NDIG-1:0][3:0]    cv_digits,
    output logic [PW-1:0]           cv_pos
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } state_t;

    state_t         state_reg;
    i2a_pkg::desc_t desc_reg;
    logic [W-1:0]   mag_reg;
    logic [W-1:0]   shift_reg;
    logic [PW-1:0]  cnt_reg;
    logic [PW-1:0]  msb_reg;
    logic           seen_reg;
    logic           accept;
    logic [W-1:0]   mag_in;
    logic [PW-1:0]  bit_idx;
    logic [NDIG:0]  carry;
    logic [PW-1:0]  dec_pos;
    logic [PW-1:0]  hex_pos;

    assign in_stall = (state_reg == S_RUN) || (state_reg == S_DONE && !cv_take);
    assign accept   = in_valid && !in_stall;
    assign mag_in   = value[W-1] ? (~value + W'(1)) : value;
    assign bit_idx  = PW'(W - 1) - cnt_reg;

    assign carry[0] = shift_reg[W-1];

    for (genvar k = 0; k < NDIG; k++)
    begin : g_cell
        i2a_bcd_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .clear    (accept),
            .shift_en (state_reg == S_RUN),
            .cin      (carry[k]),
            .cout     (carry[k+1]),
            .digit    (cv_digits[k])
        );
    end

    always_comb
    begin
        dec_pos = '0;
        for (int k = 0; k < NDIG; k++)
        begin
            if (cv_digits[k] != 4'd0)
                dec_pos = PW'(k);
        end
    end

    // two nibbles per significant byte
    assign hex_pos = PW'({(msb_reg >> 3), 1'b1});

    always_comb
    begin
        case (desc_reg.func)
            i2a_pkg::FUNC_HEX: cv_pos = hex_pos;
            i2a_pkg::FUNC_DEC: cv_pos = dec_pos;
            default:           cv_pos = msb_reg;
        endcase
    end

    assign cv_valid = (state_reg == S_DONE);
    assign cv_desc  = desc_reg;
    assign cv_mag   = mag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            msb_reg   <= '0;
            seen_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg       <= S_RUN;
                desc_reg.neg    <= value[W-1];
                desc_reg.func   <= i2a_pkg::func_t'(func);
                desc_reg.prefix <= with_prefix;
                mag_reg         <= mag_in;
                shift_reg       <= mag_in;
                cnt_reg         <= '0;
                msb_reg         <= '0;
                seen_reg        <= 1'b0;
            end
            else
            begin
                case (state_reg)
                    S_RUN:
                    begin
                        if (shift_reg[W-1] && !seen_reg)
                        begin
                            msb_reg  <= bit_idx;
                            seen_reg <= 1'b1;
                        end
                        shift_reg <= shift_reg << 1;
                        cnt_reg   <= cnt_reg + PW'(1);
                        if (cnt_reg == PW'(W - 1))
                            state_reg <= S_DONE;
                    end
                    S_DONE:
                    begin
                        if (cv_take)
                            state_reg <= S_IDLE;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

endmodule

// ===== hdl/i2a_emit.sv =====
// Character sequencer: sign, prefix, digits from the top one down, then NUL; a bad selector skips prefix and digits.
`include "integer_to_ascii_formatter_core_assert.svh"

module i2a_emit #(
    parameter int W    = 32,
    parameter int NDIG = 10,
    parameter int PW   = 5
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    hex_upper,
    input  logic                    ld_valid,
    output logic                    ld_take,
    input  i2a_pkg::desc_t          ld_desc,
    input  logic [W-1:0]            ld_mag,
    input  logic [NDIG-1:0][3:0]    ld_digits,
    input  logic [PW-1:0]           ld_pos,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [7:0]              character,
    output logic                    last,
    output logic                    status
);

    localparam int NBYTES = (W + 7) / 8;
    localparam int MAGW   = NBYTES * 8;
    localparam int DW     = $clog2(NDIG);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SIGN,
        S_PFX0,
        S_PFX1,
        S_DIG,
        S_TERM
    } state_t;

    state_t                state_reg;
    i2a_pkg::desc_t        desc_reg;
    logic [W-1:0]          mag_reg;
    logic [NDIG-1:0][3:0]  digits_reg;
    logic [PW-1:0]         pos_reg;
    logic                  out_valid_reg;
    logic [7:0]            character_reg;
    logic                  last_reg;
    logic                  status_reg;

    logic                  advance;
    logic                  free;
    logic [MAGW-1:0]       mag_pad;
    logic [3:0]            nib;
    logic [7:0]            dig_char;
    logic [7:0]            pfx_char;
    logic [7:0]            cur_char;
    state_t                after_sign;
    state_t                ld_after_sign;
    state_t                ld_first;

    assign advance = !out_valid_reg || !out_stall;
    assign free    = (state_reg == S_IDLE) || (state_reg == S_TERM && advance);
    assign ld_take = free && ld_valid;

    assign mag_pad = MAGW'(mag_reg);
    assign nib     = 4'(mag_pad >> {pos_reg, 2'b00});

    always_comb
    begin
        case (desc_reg.func)
            i2a_pkg::FUNC_HEX:
            begin
                dig_char = i2a_pkg::hex_char(nib, hex_upper);
                pfx_char = i2a_pkg::CH_X;
            end
            i2a_pkg::FUNC_DEC:
            begin
                dig_char = i2a_pkg::CH_ZERO + {4'd0, digits_reg[pos_reg[DW-1:0]]};
                pfx_char = i2a_pkg::CH_D;
            end
            default:
            begin
                dig_char = mag_reg[pos_reg] ? i2a_pkg::CH_ONE : i2a_pkg::CH_ZERO;
                pfx_char = i2a_pkg::CH_B;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            S_SIGN:  cur_char = i2a_pkg::CH_MINUS;
            S_PFX0:  cur_char = i2a_pkg::CH_ZERO;
            S_PFX1:  cur_char = pfx_char;
            S_DIG:   cur_char = dig_char;
            default: cur_char = i2a_pkg::CH_NUL;
        endcase
    end

    always_comb
    begin
        if (desc_reg.func == i2a_pkg::FUNC_BAD)
            after_sign = S_TERM;
        else if (desc_reg.prefix)
            after_sign = S_PFX0;
        else
            after_sign = S_DIG;

        if (ld_desc.func == i2a_pkg::FUNC_BAD)
            ld_after_sign = S_TERM;
        else if (ld_desc.prefix)
            ld_after_sign = S_PFX0;
        else
            ld_after_sign = S_DIG;

        ld_first = ld_desc.neg ? S_SIGN : ld_after_sign;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
            status_reg    <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= (state_reg != S_IDLE);
                character_reg <= cur_char;
                last_reg      <= (state_reg == S_TERM);
                status_reg    <= (state_reg == S_TERM) &&
                                 (desc_reg.func == i2a_pkg::FUNC_BAD);
            end
            if (ld_take)
            begin
                state_reg  <= ld_first;
                desc_reg   <= ld_desc;
                mag_reg    <= ld_mag;
                digits_reg <= ld_digits;
                pos_reg    <= ld_pos;
            end
            else if (advance)
            begin
                case (state_reg)
                    S_SIGN: state_reg <= after_sign;
                    S_PFX0: state_reg <= S_PFX1;
                    S_PFX1: state_reg <= S_DIG;
                    S_DIG:
                    begin
                        if (pos_reg == '0)
                            state_reg <= S_TERM;
                        else
                            pos_reg <= pos_reg - PW'(1);
                    end
                    S_TERM: state_reg <= S_IDLE;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign character = character_reg;
    assign last      = last_reg;
    assign status    = status_reg;

    // an error status only ever rides on the terminating beat
    `I2A_ASSERT(a_status_on_last, out_valid_reg && status_reg |-> last_reg)
    // a new item is only taken once the previous NUL has been issued
    `I2A_ASSERT(a_take_when_free, ld_take |-> state_reg == S_IDLE || state_reg == S_TERM)
    // no digit or prefix is ever produced for a bad selector
    `I2A_ASSERT(a_bad_no_digits, state_reg == S_DIG || state_reg == S_PFX0 |-> desc_reg.func != i2a_pkg::FUNC_BAD)
    // after the NUL beat is issued with no new item taken, the emitter returns to idle
    `I2A_ASSERT(a_term_then_idle, state_reg == S_TERM && advance && !ld_take |=> state_reg == S_IDLE)

endmodule

// ===== hdl/integer_to_ascii_formatter_core.sv =====
// An accepted input beat is shifted bit-serially through the BCD cell chain and then handed to
// the emitter, which sends one character per cycle through a single-character output register
// while out_stall is low. An item has at most 36 characters at 32 bits. The converter takes
// a new input beat while the emitter is still sending the previous item's characters.
// Reset (rst_n, async, active low) clears the control state and sets hex_upper_case to 0.
module integer_to_ascii_formatter_core #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic                   cfg_wr_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [VALUE_WIDTH-1:0] value,
    input  logic [1:0]             func,
    input  logic                   with_prefix,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [7:0]             character,
    output logic                   last,
    output logic                   status
);

    // decimal digits of 2^(VALUE_WIDTH-1), from log10(2) ~ 0.30103
    localparam int NDIG = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
    localparam int PW   = $clog2(VALUE_WIDTH);

    logic                   hex_upper_case_reg;
    logic                   cv_valid;
    logic                   cv_take;
    i2a_pkg::desc_t         cv_desc;
    logic [VALUE_WIDTH-1:0] cv_mag;
    logic [NDIG-1:0][3:0]   cv_digits;
    logic [PW-1:0]          cv_pos;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hex_upper_case_reg <= 1'b0;
        else if (cfg_wr_en)
            hex_upper_case_reg <= cfg_wr_data;
    end

    i2a_convert #(
        .W    (VALUE_WIDTH),
        .NDIG (NDIG),
        .PW   (PW)
    ) u_convert (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .value       (value),
        .func        (func),
        .with_prefix (with_prefix),
        .cv_valid    (cv_valid),
        .cv_take     (cv_take),
        .cv_desc     (cv_desc),
        .cv_mag      (cv_mag),
        .cv_digits   (cv_digits),
        .cv_pos      (cv_pos)
    );

    i2a_emit #(
        .W    (VALUE_WIDTH),
        .NDIG (NDIG),
        .PW   (PW)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .hex_upper (hex_upper_case_reg),
        .ld_valid  (cv_valid),
        .ld_take   (cv_take),
        .ld_desc   (cv_desc),
        .ld_mag    (cv_mag),
        .ld_digits (cv_digits),
        .ld_pos    (cv_pos),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .character (character),
        .last      (last),
        .status    (status)
    );

endmodule
